/* design/lrmp_pkg.sv */
// Shared widths, constants, types and structs of the matrix-power recurrence block.
package lrmp_pkg;

  // Modulus of every matrix entry and of the result.
  localparam int unsigned MODULUS = 10007;

  // The term index is taken in this many low bits.
  localparam int unsigned INDEX_BITS = 32;

  // The companion matrix is DIM by DIM.
  localparam int unsigned DIM     = 4;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned ENTRY_W = 2 * IDX_W;
  localparam int unsigned CNT_W   = 3 * IDX_W;
  localparam int unsigned ADDR_W  = ENTRY_W + 1;
  localparam int unsigned DEPTH   = 2 * DIM * DIM;

  // Datapath widths of the multiply-accumulate unit.
  localparam int unsigned ELEM_W = 14;
  localparam int unsigned PROD_W = 2 * ELEM_W;
  localparam int unsigned SUM_W  = PROD_W + IDX_W;
  localparam int unsigned RES_W  = ELEM_W + 1;

  // Reduction by reciprocal: q = (sum * R) >> SHIFT is floor(sum / MODULUS)
  // or one less for every sum of DIM products, so one correction suffices.
  localparam int unsigned     BARRETT_SHIFT = 40;
  localparam longint unsigned BARRETT_R     = (64'd1 << BARRETT_SHIFT) / MODULUS;
  localparam int unsigned     R_W           = 27;
  localparam int unsigned     QP_W          = SUM_W + R_W;
  localparam int unsigned     Q_W           = 16;

  typedef logic [INDEX_BITS-1:0] index_t;
  typedef logic [ELEM_W-1:0]     elem_t;
  typedef logic [PROD_W-1:0]     prod_t;
  typedef logic [SUM_W-1:0]      sum_t;
  typedef logic [RES_W-1:0]      res_t;
  typedef logic [QP_W-1:0]       qp_t;
  typedef logic [Q_W-1:0]        q_t;
  typedef logic [ENTRY_W-1:0]    entry_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [ADDR_W-1:0]     addr_t;

  // Matrix positions, row-major.
  localparam entry_t E_COEFF_PREV  = 4'd0;
  localparam entry_t E_COEFF_THIRD = 4'd2;
  localparam entry_t E_ADDEND      = 4'd3;
  localparam entry_t E_SHIFT_ONE   = 4'd4;
  localparam entry_t E_SHIFT_TWO   = 4'd9;
  localparam entry_t E_KEEP_ONE    = 4'd15;
  localparam entry_t E_RESULT      = 4'd3;

  // One operand pair issued to the multiply-accumulate unit.
  typedef struct packed {
    logic   valid;
    logic   first;
    logic   last;
    entry_t dst;
  } mac_issue_t;

  // One finished product entry coming back for write.
  typedef struct packed {
    logic   en;
    entry_t dst;
    elem_t  value;
  } mac_wr_t;

endpackage

/* design/lrmp_ram.sv */
// Generic RAM with one write port and two registered read ports.
module lrmp_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 32,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AddrW-1:0] rd_addr_a,
  output logic [WIDTH-1:0] rd_data_a,
  input  logic [AddrW-1:0] rd_addr_b,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

/* design/lrmp_mac.sv */
// Pipelined modular multiply-accumulate unit shared by every matrix product.
module lrmp_mac (
  input  logic                 clk,
  input  logic                 rst,
  input  lrmp_pkg::mac_issue_t issue,
  input  lrmp_pkg::elem_t      x_data,
  input  lrmp_pkg::elem_t      y_data,
  output lrmp_pkg::mac_wr_t    wr,
  output logic                 busy
);

  lrmp_pkg::mac_issue_t s0;
  lrmp_pkg::mac_issue_t s1;
  lrmp_pkg::prod_t      prod;
  logic                 s2_valid;
  lrmp_pkg::entry_t     s2_dst;
  lrmp_pkg::sum_t       s2_sum;
  logic                 s3_valid;
  lrmp_pkg::entry_t     s3_dst;
  lrmp_pkg::sum_t       s3_sum;
  lrmp_pkg::q_t         s3_q;
  lrmp_pkg::qp_t        qp;
  lrmp_pkg::sum_t       r_wide;
  lrmp_pkg::res_t       r;
  lrmp_pkg::elem_t      value;
  logic                 wr_en;
  lrmp_pkg::entry_t     wr_dst;
  lrmp_pkg::elem_t      wr_value;

  // Stage 0 lines the issue up with the registered RAM read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0       <= '0;
      s1       <= '0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      wr_en    <= 1'b0;
    end else begin
      s0       <= issue;
      s1       <= s0;
      s2_valid <= s1.valid & s1.last;
      s3_valid <= s2_valid;
      wr_en    <= s3_valid;
    end
  end

  assign qp = lrmp_pkg::qp_t'(s2_sum) *
              lrmp_pkg::qp_t'(lrmp_pkg::BARRETT_R[lrmp_pkg::R_W-1:0]);

  always_comb begin
    r_wide = s3_sum - lrmp_pkg::sum_t'(s3_q) * lrmp_pkg::sum_t'(lrmp_pkg::MODULUS);
    r      = r_wide[lrmp_pkg::RES_W-1:0];
    if (r >= lrmp_pkg::res_t'(lrmp_pkg::MODULUS)) begin
      value = lrmp_pkg::elem_t'(r - lrmp_pkg::res_t'(lrmp_pkg::MODULUS));
    end else begin
      value = lrmp_pkg::elem_t'(r);
    end
  end

  always_ff @(posedge clk) begin
    prod <= lrmp_pkg::prod_t'(x_data) * lrmp_pkg::prod_t'(y_data);
    if (s1.valid) begin
      if (s1.first) begin
        s2_sum <= lrmp_pkg::sum_t'(prod);
      end else begin
        s2_sum <= s2_sum + lrmp_pkg::sum_t'(prod);
      end
    end
    s2_dst   <= s1.dst;
    s3_q     <= qp[lrmp_pkg::BARRETT_SHIFT +: lrmp_pkg::Q_W];
    s3_sum   <= s2_sum;
    s3_dst   <= s2_dst;
    wr_dst   <= s3_dst;
    wr_value <= value;
  end

  assign wr = {wr_en, wr_dst, wr_value};

  assign busy = s0.valid | s1.valid | s2_valid | s3_valid | wr_en;

  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> s2_sum < lrmp_pkg::sum_t'(lrmp_pkg::DIM * lrmp_pkg::MODULUS *
                                          lrmp_pkg::MODULUS))
    else $error("accumulated sum exceeds the bound of four products");

  a_one_correction: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> r_wide < lrmp_pkg::sum_t'(2 * lrmp_pkg::MODULUS))
    else $error("reciprocal quotient is off by more than one");

  a_value_reduced: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> wr.value < lrmp_pkg::elem_t'(lrmp_pkg::MODULUS))
    else $error("product entry is not reduced");

endmodule

/* design/linear_recurrence_matrix_power_mod.sv */
// Top level: third-order recurrence mod 10007 by square-and-multiply of a 4x4 matrix.
// An index of 2 or less goes straight to the result; a larger one first loads the
// matrices, then runs an optional multiply and a square for each bit of n-2: each product
// is 64 operand-pair issues on the shared multiply-accumulate unit plus a pipeline drain.
// Throughput: one word at a time; in_stall is high from acceptance until the result moves
// into the output register, which may still hold an earlier word meanwhile.
// Reset (synchronous, active high) returns the sequencer to idle and empties the output.
module linear_recurrence_matrix_power_mod (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [lrmp_pkg::INDEX_BITS-1:0]    term_index,
  input  logic [lrmp_pkg::ELEM_W-1:0]        coeff_prev,
  input  logic [lrmp_pkg::ELEM_W-1:0]        coeff_third,
  input  logic [lrmp_pkg::ELEM_W-1:0]        addend,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [lrmp_pkg::ELEM_W-1:0]        term_value
);

  // One-hot sequencer states.
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_INIT = 8'b0000_0010,
    S_PICK = 8'b0000_0100,
    S_MUL  = 8'b0000_1000,
    S_SQR  = 8'b0001_0000,
    S_WAIT = 8'b0010_0000,
    S_READ = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t               state;
  state_t               state_next;
  lrmp_pkg::cnt_t       cnt;
  lrmp_pkg::index_t     exp_left;
  logic                 acc_bank;
  logic                 pow_bank;
  logic                 op_sqr;
  logic                 small_index;
  lrmp_pkg::elem_t      coef_a;
  lrmp_pkg::elem_t      coef_b;
  lrmp_pkg::elem_t      coef_c;

  logic                 in_accept;
  logic                 out_load;
  logic                 cnt_last;
  logic                 mac_busy;
  lrmp_pkg::mac_issue_t issue;
  lrmp_pkg::mac_wr_t    mac_wr;
  lrmp_pkg::elem_t      red_a;
  lrmp_pkg::elem_t      red_b;
  lrmp_pkg::elem_t      red_c;

  lrmp_pkg::idx_t       row_i;
  lrmp_pkg::idx_t       col_j;
  lrmp_pkg::idx_t       mid_k;
  lrmp_pkg::entry_t     init_entry;
  lrmp_pkg::elem_t      init_pow;
  lrmp_pkg::elem_t      init_acc;
  logic                 init_wr;

  logic                 acc_wr_en;
  lrmp_pkg::addr_t      acc_wr_addr;
  lrmp_pkg::elem_t      acc_wr_data;
  lrmp_pkg::addr_t      acc_rd_addr_a;
  lrmp_pkg::addr_t      acc_rd_addr_b;
  lrmp_pkg::elem_t      acc_rd_a;
  lrmp_pkg::elem_t      acc_rd_b;
  logic                 pow_wr_en;
  lrmp_pkg::addr_t      pow_wr_addr;
  lrmp_pkg::elem_t      pow_wr_data;
  lrmp_pkg::addr_t      pow_rd_addr_a;
  lrmp_pkg::addr_t      pow_rd_addr_b;
  lrmp_pkg::elem_t      pow_rd_a;
  lrmp_pkg::elem_t      pow_rd_b;

  // A new word is taken only while the sequencer is idle.
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid & ~in_stall;

  // The result moves into the output register once it is empty or being taken.
  assign out_load = (state == S_DONE) & (~out_valid | ~out_stall);

  // Coefficient fields can hold up to 16383, so a single subtraction reduces them.
  always_comb begin
    red_a = (coeff_prev  >= lrmp_pkg::elem_t'(lrmp_pkg::MODULUS)) ?
            coeff_prev  - lrmp_pkg::elem_t'(lrmp_pkg::MODULUS) : coeff_prev;
    red_b = (coeff_third >= lrmp_pkg::elem_t'(lrmp_pkg::MODULUS)) ?
            coeff_third - lrmp_pkg::elem_t'(lrmp_pkg::MODULUS) : coeff_third;
    red_c = (addend      >= lrmp_pkg::elem_t'(lrmp_pkg::MODULUS)) ?
            addend      - lrmp_pkg::elem_t'(lrmp_pkg::MODULUS) : addend;
  end

  // The issue counter walks row i, column j and inner index k of the product;
  // during the load the low bits walk the sixteen entries.
  assign row_i      = cnt[3*lrmp_pkg::IDX_W-1:2*lrmp_pkg::IDX_W];
  assign col_j      = cnt[2*lrmp_pkg::IDX_W-1:lrmp_pkg::IDX_W];
  assign mid_k      = cnt[lrmp_pkg::IDX_W-1:0];
  assign init_entry = cnt[lrmp_pkg::ENTRY_W-1:0];

  always_comb begin
    if (state == S_INIT) begin
      cnt_last = (cnt == lrmp_pkg::cnt_t'(lrmp_pkg::DIM * lrmp_pkg::DIM - 1));
    end else begin
      cnt_last = (cnt == lrmp_pkg::cnt_t'(lrmp_pkg::DIM * lrmp_pkg::DIM *
                                          lrmp_pkg::DIM - 1));
    end
  end

  // Starting values: the companion matrix and the identity.
  always_comb begin
    unique case (init_entry)
      lrmp_pkg::E_COEFF_PREV:  init_pow = coef_a;
      lrmp_pkg::E_COEFF_THIRD: init_pow = coef_b;
      lrmp_pkg::E_ADDEND:      init_pow = coef_c;
      lrmp_pkg::E_SHIFT_ONE:   init_pow = lrmp_pkg::elem_t'(1);
      lrmp_pkg::E_SHIFT_TWO:   init_pow = lrmp_pkg::elem_t'(1);
      lrmp_pkg::E_KEEP_ONE:    init_pow = lrmp_pkg::elem_t'(1);
      default:                 init_pow = '0;
    endcase
    init_acc = (init_entry[lrmp_pkg::ENTRY_W-1:lrmp_pkg::IDX_W] ==
                init_entry[lrmp_pkg::IDX_W-1:0]) ? lrmp_pkg::elem_t'(1) : '0;
  end

  assign init_wr = (state == S_INIT);

  // Sources come from the current bank of each store and products go to the
  // other bank, so a product never overwrites an entry it still has to read.
  assign acc_rd_addr_a = {acc_bank, row_i, mid_k};
  assign acc_rd_addr_b = {acc_bank, lrmp_pkg::E_RESULT};
  assign pow_rd_addr_a = {pow_bank, row_i, mid_k};
  assign pow_rd_addr_b = {pow_bank, mid_k, col_j};

  always_comb begin
    if (init_wr) begin
      acc_wr_en   = 1'b1;
      acc_wr_addr = {1'b0, init_entry};
      acc_wr_data = init_acc;
      pow_wr_en   = 1'b1;
      pow_wr_addr = {1'b0, init_entry};
      pow_wr_data = init_pow;
    end else begin
      acc_wr_en   = mac_wr.en & ~op_sqr;
      acc_wr_addr = {~acc_bank, mac_wr.dst};
      acc_wr_data = mac_wr.value;
      pow_wr_en   = mac_wr.en & op_sqr;
      pow_wr_addr = {~pow_bank, mac_wr.dst};
      pow_wr_data = mac_wr.value;
    end
  end

  always_comb begin
    issue.valid = (state == S_MUL) | (state == S_SQR);
    issue.first = (mid_k == '0);
    issue.last  = (mid_k == lrmp_pkg::idx_t'(lrmp_pkg::DIM - 1));
    issue.dst   = {row_i, col_j};
  end

  lrmp_ram #(
    .WIDTH (lrmp_pkg::ELEM_W),
    .DEPTH (lrmp_pkg::DEPTH)
  ) u_acc_ram (
    .clk       (clk),
    .wr_en     (acc_wr_en),
    .wr_addr   (acc_wr_addr),
    .wr_data   (acc_wr_data),
    .rd_addr_a (acc_rd_addr_a),
    .rd_data_a (acc_rd_a),
    .rd_addr_b (acc_rd_addr_b),
    .rd_data_b (acc_rd_b)
  );

  lrmp_ram #(
    .WIDTH (lrmp_pkg::ELEM_W),
    .DEPTH (lrmp_pkg::DEPTH)
  ) u_pow_ram (
    .clk       (clk),
    .wr_en     (pow_wr_en),
    .wr_addr   (pow_wr_addr),
    .wr_data   (pow_wr_data),
    .rd_addr_a (pow_rd_addr_a),
    .rd_data_a (pow_rd_a),
    .rd_addr_b (pow_rd_addr_b),
    .rd_data_b (pow_rd_b)
  );

  // Left operand is the accumulated power for a multiply and the power itself
  // for a square; the right operand is always the power.
  lrmp_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .issue  (issue),
    .x_data (op_sqr ? pow_rd_a : acc_rd_a),
    .y_data (pow_rd_b),
    .wr     (mac_wr),
    .busy   (mac_busy)
  );

  // Sequencer: each exponent bit, least significant first, gives an optional
  // multiply into the accumulated power and then a square of the power.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          state_next = (term_index <= lrmp_pkg::index_t'(2)) ? S_DONE : S_INIT;
        end
      end
      S_INIT: begin
        if (cnt_last) begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        priority if (exp_left == '0) begin
          state_next = S_READ;
        end else if (exp_left[0]) begin
          state_next = S_MUL;
        end else begin
          state_next = S_SQR;
        end
      end
      S_MUL, S_SQR: begin
        if (cnt_last) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!mac_busy) begin
          state_next = op_sqr ? S_PICK : S_SQR;
        end
      end
      S_READ: state_next = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      exp_left  <= '0;
      acc_bank  <= 1'b0;
      pow_bank  <= 1'b0;
      op_sqr    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if ((state == S_INIT) || (state == S_MUL) || (state == S_SQR)) begin
        cnt <= cnt_last ? '0 : cnt + lrmp_pkg::cnt_t'(1);
      end else begin
        cnt <= '0;
      end

      if (in_accept) begin
        exp_left <= term_index - lrmp_pkg::index_t'(2);
        acc_bank <= 1'b0;
        pow_bank <= 1'b0;
      end

      if ((state == S_PICK) && (exp_left != '0)) begin
        op_sqr <= ~exp_left[0];
      end

      // A finished product swaps banks; a finished square also consumes the bit.
      if ((state == S_WAIT) && !mac_busy) begin
        if (op_sqr) begin
          pow_bank <= ~pow_bank;
          exp_left <= exp_left >> 1;
        end else begin
          acc_bank <= ~acc_bank;
          op_sqr   <= 1'b1;
        end
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Word payload, no reset needed.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      coef_a      <= red_a;
      coef_b      <= red_b;
      coef_c      <= red_c;
      small_index <= (term_index <= lrmp_pkg::index_t'(2));
    end
    if (out_load) begin
      term_value <= small_index ? '0 : acc_rd_b;
    end
  end

  a_drained: assert property (@(posedge clk) disable iff (rst)
    ((state == S_IDLE) || (state == S_PICK) || (state == S_READ)) |-> !mac_busy)
    else $error("multiply-accumulate unit still busy outside a product");

  a_exp_live: assert property (@(posedge clk) disable iff (rst)
    ((state == S_MUL) || (state == S_SQR)) |-> (exp_left != '0))
    else $error("product issued with no exponent bits left");

  a_small_zero: assert property (@(posedge clk) disable iff (rst)
    (out_load && small_index) |=> (term_value == '0))
    else $error("small index did not give zero");

  a_out_reduced: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (term_value < lrmp_pkg::elem_t'(lrmp_pkg::MODULUS)))
    else $error("result word is not reduced");

endmodule
